>>> rtl/clct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clct_pkg
// Shared types and constants for the character-LCD cursor terminal.
// ----------------------------------------------------------------------------
package clct_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_MOVE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Special characters and LCD bytes
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ADDR_ROW_ODD = 8'h40;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] CFG_ROW_BREAK    = 2'd2;
    localparam logic [1:0] CFG_LINE_END     = 2'd3;

    // Configuration reset values
    localparam logic [2:0] ROW_COUNT_RST    = 3'd2;
    localparam logic [5:0] COLUMN_COUNT_RST = 6'd16;
    localparam logic [5:0] ROW_BREAK_RST    = 6'd16;
    localparam logic [5:0] LINE_END_RST     = 6'd16;

    // Tab expansion
    localparam int TAB_SPACING = 4;
    localparam int TAB_CNT_W   = $clog2(TAB_SPACING + 1);
    localparam logic [TAB_CNT_W-1:0] TAB_LAST = TAB_CNT_W'(TAB_SPACING - 1);

    // Remainder unit: one quotient bit per cycle over a 6-bit column
    localparam logic [2:0] DIV_STEPS = 3'd6;

    // Move operand load selection
    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_TGT  = 2'd1;
    localparam logic [1:0] LD_NL   = 2'd2;
    localparam logic [1:0] LD_CUR  = 2'd3;

    typedef struct packed {
        logic       latch_in;
        logic [1:0] load_op;
        logic       emit_print;
        logic       emit_move;
        logic       emit_clear;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic       div_busy;
        logic [1:0] func;
        logic       is_nl;
        logic       is_tab;
        logic       wrap;
        logic       split;
        logic       tab_end;
    } dp_status_t;

endpackage

>>> rtl/clct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clct_ctrl
// Sequencer: decodes each input word and steps through the data, newline,
// set-address and clear writes it causes.
// ----------------------------------------------------------------------------
module clct_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  clct_pkg::dp_status_t  status,
    output clct_pkg::dp_cmd_t     cmd
);
    import clct_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRINT = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_CLR   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic                 nl_pend_reg, nl_pend_next;
    logic                 split_pend_reg, split_pend_next;
    logic                 tab_more_reg, tab_more_next;
    logic                 tab_reg, tab_next;
    logic [TAB_CNT_W-1:0] tab_cnt_reg, tab_cnt_next;
    logic                 tab_go;

    assign in_ready = (state_reg == S_IDLE);

    // Another space follows when no wrap happened and the stop is not reached
    assign tab_go = tab_reg && !status.wrap && !status.tab_end && (tab_cnt_reg != TAB_LAST);

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        nl_pend_next    = nl_pend_reg;
        split_pend_next = split_pend_reg;
        tab_more_next   = tab_more_reg;
        tab_next        = tab_reg;
        tab_cnt_next    = tab_cnt_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in    = 1'b1;
                    nl_pend_next    = 1'b0;
                    split_pend_next = 1'b0;
                    tab_more_next   = 1'b0;
                    tab_cnt_next    = '0;
                    tab_next        = status.is_tab;
                    case (status.func)
                        FUNC_PUT:
                        begin
                            if (status.is_nl)
                            begin
                                cmd.load_op = LD_NL;
                                tab_next    = 1'b0;
                                state_next  = S_MOVE;
                            end
                            else
                            begin
                                state_next = S_PRINT;
                            end
                        end
                        FUNC_MOVE:
                        begin
                            cmd.load_op = LD_TGT;
                            tab_next    = 1'b0;
                            state_next  = S_MOVE;
                        end
                        FUNC_CLEAR:
                        begin
                            tab_next   = 1'b0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            tab_next   = 1'b0;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PRINT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_print  = 1'b1;
                    cmd.last        = !(status.wrap || status.split || tab_go);
                    nl_pend_next    = status.wrap;
                    split_pend_next = status.split;
                    tab_more_next   = tab_go;
                    tab_cnt_next    = tab_cnt_reg + 1'b1;
                    if (status.wrap || status.split)
                        state_next = S_LOAD;
                    else if (tab_go)
                        state_next = S_PRINT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                // Newline move goes first, then the split-layout re-move
                if (nl_pend_reg)
                begin
                    cmd.load_op  = LD_NL;
                    nl_pend_next = 1'b0;
                end
                else
                begin
                    cmd.load_op     = LD_CUR;
                    split_pend_next = 1'b0;
                end
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                if (!status.div_busy && status.out_free)
                begin
                    cmd.emit_move = 1'b1;
                    cmd.last      = !(split_pend_reg || tab_more_reg);
                    if (split_pend_reg)
                        state_next = S_LOAD;
                    else if (tab_more_reg)
                        state_next = S_PRINT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_clear = 1'b1;
                    cmd.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nl_pend_reg    <= 1'b0;
            split_pend_reg <= 1'b0;
            tab_more_reg   <= 1'b0;
            tab_reg        <= 1'b0;
            tab_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            nl_pend_reg    <= nl_pend_next;
            split_pend_reg <= split_pend_next;
            tab_more_reg   <= tab_more_next;
            tab_reg        <= tab_next;
            tab_cnt_reg    <= tab_cnt_next;
        end
    end

endmodule

>>> rtl/clct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clct_datapath
// Configuration and cursor registers, serial remainder unit, address
// formation and the output word register.
// ----------------------------------------------------------------------------
module clct_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [1:0]            func,
    input  logic [7:0]            char_code,
    input  logic [1:0]            target_row,
    input  logic [5:0]            target_col,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  is_data,
    output logic [7:0]            bus_byte,
    output logic                  last,
    input  clct_pkg::dp_cmd_t     cmd,
    output clct_pkg::dp_status_t  status
);
    import clct_pkg::*;

    logic [2:0] row_count_reg;
    logic [5:0] column_count_reg;
    logic [5:0] row_break_reg;
    logic [5:0] line_end_reg;

    logic [1:0] cursor_row_reg, cursor_row_next;
    logic [5:0] cursor_col_reg, cursor_col_next;
    logic [7:0] char_reg;
    logic       tab_char_reg;
    logic [1:0] mrow_reg;
    logic [5:0] mcol_reg;
    logic [2:0] div_cnt_reg;
    logic [5:0] rem_reg;

    logic       out_valid_reg, out_valid_next;
    logic       is_data_reg;
    logic [7:0] bus_byte_reg;
    logic       last_reg;

    logic       split;
    logic       four_row;
    logic [5:0] divisor;
    logic [6:0] trial;
    logic [2:0] bit_idx;
    logic [5:0] new_col;
    logic [2:0] row_inc;
    logic [1:0] nl_row;
    logic [7:0] addr;
    logic [7:0] print_byte;

    assign split    = (row_break_reg > line_end_reg);
    assign four_row = (row_count_reg == 3'd4);
    assign divisor  = split ? line_end_reg : row_break_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RST;
            column_count_reg <= COLUMN_COUNT_RST;
            row_break_reg    <= ROW_BREAK_RST;
            line_end_reg     <= LINE_END_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data[2:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[5:0];
                CFG_ROW_BREAK:    row_break_reg    <= cfg_data[5:0];
                CFG_LINE_END:     line_end_reg     <= cfg_data[5:0];
                default:          ;
            endcase
        end
    end

    // Print advance and newline row
    assign new_col = cursor_col_reg + 6'd1;
    assign row_inc = {1'b0, cursor_row_reg} + 3'd1;
    assign nl_row  = (row_inc >= row_count_reg) ? 2'd0 : row_inc[1:0];

    // Hold the character of the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            char_reg     <= char_code;
            tab_char_reg <= (char_code == CHAR_TAB);
        end
    end

    // Load move operands
    always_ff @(posedge clk)
    begin
        case (cmd.load_op)
            LD_TGT:
            begin
                mrow_reg <= target_row;
                mcol_reg <= target_col;
            end
            LD_NL:
            begin
                mrow_reg <= nl_row;
                mcol_reg <= 6'd0;
            end
            LD_CUR:
            begin
                mrow_reg <= cursor_row_reg;
                mcol_reg <= cursor_col_reg;
            end
            default: ;
        endcase
    end

    // Restoring remainder, one column bit per cycle; a zero divisor leaves the column
    assign bit_idx = div_cnt_reg - 3'd1;
    assign trial   = {rem_reg, mcol_reg[bit_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= 3'd0;
        else if (cmd.load_op != LD_NONE)
            div_cnt_reg <= DIV_STEPS;
        else if (div_cnt_reg != 3'd0)
            div_cnt_reg <= div_cnt_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op != LD_NONE)
            rem_reg <= 6'd0;
        else if (div_cnt_reg != 3'd0)
        begin
            if (trial >= {1'b0, divisor})
                rem_reg <= 6'(trial - {1'b0, divisor});
            else
                rem_reg <= trial[5:0];
        end
    end

    // Form the DDRAM address for the layout in force
    always_comb
    begin
        addr = 8'd0;
        if (split)
        begin
            if ((line_end_reg != 6'd0) && (mcol_reg >= line_end_reg))
                addr = ADDR_ROW_ODD;
            addr = addr | {2'b00, rem_reg};
        end
        else if (four_row)
        begin
            if (mrow_reg[0])
                addr = ADDR_ROW_ODD;
            if (mrow_reg[1])
                addr = addr + {2'b00, row_break_reg};
            addr = addr + {2'b00, rem_reg};
        end
        else
        begin
            if (mrow_reg != 2'd0)
                addr = ADDR_ROW_ODD;
            addr = addr | {2'b00, mcol_reg};
        end
    end

    assign print_byte = tab_char_reg ? CHAR_SPACE : char_reg;

    // Cursor update
    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        if (cmd.emit_print)
            cursor_col_next = new_col;
        else if (cmd.emit_move)
        begin
            cursor_row_next = mrow_reg;
            cursor_col_next = mcol_reg;
        end
        else if (cmd.emit_clear)
        begin
            cursor_row_next = 2'd0;
            cursor_col_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 2'd0;
            cursor_col_reg <= 6'd0;
        end
        else
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

    // Output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_print || cmd.emit_move || cmd.emit_clear)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_print)
        begin
            is_data_reg  <= 1'b1;
            bus_byte_reg <= print_byte;
            last_reg     <= cmd.last;
        end
        else if (cmd.emit_move)
        begin
            is_data_reg  <= 1'b0;
            bus_byte_reg <= addr | CMD_SET_ADDR;
            last_reg     <= cmd.last;
        end
        else if (cmd.emit_clear)
        begin
            is_data_reg  <= 1'b0;
            bus_byte_reg <= CMD_CLEAR;
            last_reg     <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign bus_byte  = bus_byte_reg;
    assign last      = last_reg;

    // Status to the sequencer
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.div_busy = (div_cnt_reg != 3'd0);
    assign status.func     = func;
    assign status.is_nl    = (char_code == CHAR_NL);
    assign status.is_tab   = (char_code == CHAR_TAB);
    assign status.wrap     = (new_col >= column_count_reg);
    assign status.split    = split;
    assign status.tab_end  = ((new_col % TAB_SPACING) == 0);

endmodule

>>> rtl/char_lcd_cursor_terminal.sv
`timescale 1ns / 1ps
// Order: the word is latched in IDLE; a data write enters the output register from S_PRINT
// once the output is free; a set-address write from S_MOVE once the six-step remainder unit
// is done. Throughput: one input word in IDLE only, so a new word waits until every write of
// the last one is emitted; wraps, split layouts and tab spaces add writes, output stalls
// hold the sequencer. Reset: asynchronous active-low rst_n clears the cursor to row 0
// column 0, loads 2 rows, 16 columns, break 16, line end 16, empties output.
// ----------------------------------------------------------------------------
// char_lcd_cursor_terminal
// Character-LCD front end: turns put, move and clear words into LCD byte writes.
// ----------------------------------------------------------------------------
module char_lcd_cursor_terminal
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic [1:0] target_row,
    input  logic [5:0] target_col,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_data,
    output logic [7:0] bus_byte,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import clct_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    clct_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    clct_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .is_data    (is_data),
        .bus_byte   (bus_byte),
        .last       (last),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
